@@ rtl/core/pibank_pkg.sv @@
// Shared types, constants and the sample packing function of the panel input register bank.
package pibank_pkg;

    localparam int unsigned REGISTER_COUNT_DEF = 10;
    localparam int unsigned LowCount = 9;
    localparam int unsigned LowAw = 4;

    localparam logic [2:0] ACT_ADDR_MATCH = 3'd0;
    localparam logic [2:0] ACT_RX_BYTE = 3'd1;
    localparam logic [2:0] ACT_TX_REQ = 3'd2;
    localparam logic [2:0] ACT_STOP = 3'd3;
    localparam logic [2:0] ACT_ERROR = 3'd4;
    localparam logic [2:0] ACT_LEFT_EDGE = 3'd5;
    localparam logic [2:0] ACT_RIGHT_EDGE = 3'd6;
    localparam logic [2:0] ACT_SAMPLE = 3'd7;

    localparam logic [7:0] SAMPLE_ARM = 8'h10;

    localparam logic [1:0] SRC_ZERO = 2'd0;
    localparam logic [1:0] SRC_LOW = 2'd1;
    localparam logic [1:0] SRC_RAM = 2'd2;

    typedef struct packed {
        logic [2:0]  action;
        logic        host_writes;
        logic [7:0]  rx_byte;
        logic        encoder_b_level;
        logic [9:0]  adc_first;
        logic [9:0]  adc_second;
        logic [29:0] key_rows;
    } t_in_item;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       sample_taken;
    } t_out_item;

    typedef struct packed {
        logic       tx_valid;
        logic       sample_taken;
        logic [1:0] src;
        logic [7:0] low_data;
        logic       ram_written;
        logic [7:0] fill;
    } t_res_info;

    typedef logic [LowCount-2:0][7:0] t_pack;

    function automatic t_pack pack_sample(input logic [3:0] dl, input logic [3:0] dr,
                                          input logic [9:0] adc1, input logic [9:0] adc2,
                                          input logic [29:0] keys);
        t_pack p;
        p[0] = {dl, 2'b00, adc1[9:8]};
        p[1] = adc1[7:0];
        p[2] = {dr, 2'b00, adc2[9:8]};
        p[3] = adc2[7:0];
        p[4] = {2'b00, keys[29:25], keys[24]};
        p[5] = {keys[23:20], keys[19:16]};
        p[6] = {keys[15], keys[14:10], keys[9:8]};
        p[7] = {keys[7:5], keys[4:0]};
        return p;
    endfunction

endpackage

@@ rtl/core/pibank_ram.sv @@
// Generic single-port-write RAM with a registered, enabled read port.
module pibank_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1,
    parameter int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/core/pibank_ctrl.sv @@
// Bus pointer, register bank, encoder counters and sample packing for one item.
module pibank_ctrl #(
    parameter int unsigned REGISTER_COUNT = pibank_pkg::REGISTER_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_go,
    input  pibank_pkg::t_in_item i_item,
    output pibank_pkg::t_res_info o_res,
    output logic [7:0]           o_rdata
);
    import pibank_pkg::*;

    localparam int unsigned RamDepth = REGISTER_COUNT - LowCount;
    localparam int unsigned RamAw = (RamDepth > 1) ? $clog2(RamDepth) : 1;

    logic [7:0]          r_ptr;
    logic                r_expect;
    logic [3:0]          r_left;
    logic [3:0]          r_right;
    logic [3:0]          r_left_rep;
    logic [3:0]          r_right_rep;
    logic [7:0]          r_low [LowCount];
    logic [RamDepth-1:0] r_written;

    logic [8:0]       ptr_inc;
    logic [7:0]       ptr_next;
    logic             in_range;
    logic             ptr_low;
    logic [LowAw-1:0] low_idx;
    logic [RamAw-1:0] ram_idx;
    logic             armed;
    logic             do_sample;
    logic             do_write;
    logic             ram_we;
    logic             ram_re;
    t_pack            packed_regs;

    assign ptr_inc = {1'b0, r_ptr} + 9'd1;
    assign ptr_next = (ptr_inc >= 9'(REGISTER_COUNT)) ? 8'd0 : ptr_inc[7:0];
    assign in_range = r_ptr < 8'(REGISTER_COUNT);
    assign ptr_low = r_ptr < 8'(LowCount);
    assign low_idx = r_ptr[LowAw-1:0];
    assign ram_idx = RamAw'(r_ptr - 8'(LowCount));
    assign armed = r_low[0] == SAMPLE_ARM;
    assign do_sample = i_go && (i_item.action == ACT_SAMPLE) && armed;
    assign do_write = i_go && (i_item.action == ACT_RX_BYTE) && !r_expect;
    assign ram_we = do_write && in_range && !ptr_low;
    assign ram_re = i_go && (i_item.action == ACT_TX_REQ) && in_range && !ptr_low;
    assign packed_regs = pack_sample(r_left - r_left_rep, r_right - r_right_rep,
                                     i_item.adc_first, i_item.adc_second, i_item.key_rows);

    always_comb begin
        o_res = '0;
        o_res.fill = r_ptr;
        o_res.src = SRC_ZERO;
        o_res.tx_valid = i_item.action == ACT_TX_REQ;
        o_res.sample_taken = (i_item.action == ACT_SAMPLE) && armed;
        if (o_res.tx_valid && in_range) begin
            o_res.src = ptr_low ? SRC_LOW : SRC_RAM;
        end
        if (ptr_low) begin
            o_res.low_data = r_low[low_idx];
        end
        if (in_range && !ptr_low) begin
            o_res.ram_written = r_written[ram_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
            r_expect <= 1'b0;
            r_left <= '0;
            r_right <= '0;
            r_left_rep <= '0;
            r_right_rep <= '0;
            r_written <= '0;
            for (int i = 0; i < LowCount; i++) begin
                r_low[i] <= 8'(i);
            end
        end else if (i_go) begin
            unique case (i_item.action)
                ACT_ADDR_MATCH: begin
                    if (i_item.host_writes) begin
                        r_expect <= 1'b1;
                    end
                end
                ACT_RX_BYTE: begin
                    if (r_expect) begin
                        r_ptr <= i_item.rx_byte;
                        r_expect <= 1'b0;
                    end else begin
                        if (ptr_low) begin
                            r_low[low_idx] <= i_item.rx_byte;
                        end
                        if (ram_we) begin
                            r_written[ram_idx] <= 1'b1;
                        end
                        r_ptr <= ptr_next;
                    end
                end
                ACT_TX_REQ: begin
                    r_ptr <= ptr_next;
                end
                ACT_STOP, ACT_ERROR: begin
                    r_ptr <= '0;
                end
                ACT_LEFT_EDGE: begin
                    r_left <= i_item.encoder_b_level ? r_left - 4'd1 : r_left + 4'd1;
                end
                ACT_RIGHT_EDGE: begin
                    r_right <= i_item.encoder_b_level ? r_right - 4'd1 : r_right + 4'd1;
                end
                ACT_SAMPLE: begin
                    if (do_sample) begin
                        r_left_rep <= r_left;
                        r_right_rep <= r_right;
                        r_low[0] <= 8'd0;
                        for (int k = 1; k < LowCount; k++) begin
                            r_low[k] <= packed_regs[k-1];
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    pibank_ram #(
        .WIDTH(8),
        .DEPTH(RamDepth)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_idx),
        .i_wdata(i_item.rx_byte),
        .i_re   (ram_re),
        .i_raddr(ram_idx),
        .o_rdata(o_rdata)
    );
endmodule

@@ rtl/core/pibank_out.sv @@
// Result register stage that assembles the transmitted byte and flags.
module pibank_out (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_go,
    input  pibank_pkg::t_res_info i_res,
    input  logic [7:0]            i_rdata,
    input  logic                  i_out_stall,
    output logic                  o_ready,
    output logic                  o_out_valid,
    output pibank_pkg::t_out_item o_out_item
);
    import pibank_pkg::*;

    logic      r_valid;
    t_res_info r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_res <= i_res;
        end
    end

    assign o_ready = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;

    always_comb begin
        o_out_item.tx_valid = r_res.tx_valid;
        o_out_item.sample_taken = r_res.sample_taken;
        case (r_res.src)
            SRC_LOW: o_out_item.tx_byte = r_res.low_data;
            SRC_RAM: o_out_item.tx_byte = r_res.ram_written ? i_rdata : r_res.fill;
            default: o_out_item.tx_byte = 8'd0;
        endcase
    end
endmodule

@@ rtl/core/panel_input_register_bank_top.sv @@
// Top level of the panel input register bank: input stage, control and result stage.
//
//   Channel | Direction | Handshake                 | Payload
//   input   | in        | i_in_valid / o_in_stall   | i_in_item  (t_in_item)
//   output  | out       | o_out_valid / i_out_stall | o_out_item (t_out_item)
//
// Every item gives one result, held in the input register and then in the result register, and a
// new item is taken in every cycle unless the input stalls; the registered read port of the bank
// memory lands together with the result register.
// Reset is synchronous and active low; it restores the bank to its index values.
// A stalled result holds its stage, and the input stalls only when both stages are full.
module panel_input_register_bank_top #(
    parameter int unsigned REGISTER_COUNT = pibank_pkg::REGISTER_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  pibank_pkg::t_in_item  i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output pibank_pkg::t_out_item o_out_item
);
    import pibank_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      s2_ready;
    logic      go;
    t_res_info res;
    logic [7:0] rdata;

    assign go = r_in_valid && s2_ready;
    assign o_in_stall = r_in_valid && !s2_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_item <= i_in_item;
        end
    end

    pibank_ctrl #(
        .REGISTER_COUNT(REGISTER_COUNT)
    ) u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (go),
        .i_item (r_in_item),
        .o_res  (res),
        .o_rdata(rdata)
    );

    pibank_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (go),
        .i_res      (res),
        .i_rdata    (rdata),
        .i_out_stall(i_out_stall),
        .o_ready    (s2_ready),
        .o_out_valid(o_out_valid),
        .o_out_item (o_out_item)
    );
endmodule

@@ rtl/core/pibank_chk.sv @@
// Port checker for the panel input register bank and its bind to the top level.
module pibank_chk (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input pibank_pkg::t_out_item o_out_item
);
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    a_one_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.tx_valid && o_out_item.sample_taken))
        else $error("transmit and sample flags both set");

    a_tx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.tx_valid |-> o_out_item.tx_byte == 8'd0)
        else $error("byte present without transmit");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled while result stage empty");
endmodule

bind panel_input_register_bank_top pibank_chk u_pibank_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_item (o_out_item)
);
